@@ src/ldm_pkg.sv @@
// ----------------------------------------------------------------------------
// ldm_pkg: shared types and constants for the linear delta move planner
// Field widths, configuration register codes, pipeline sideband structs and
// the goal step saturation helper.
// ----------------------------------------------------------------------------
package ldm_pkg;

  localparam int FRAC_BITS_DEF = 8;

  // Port field widths
  localparam int X_W       = 19;
  localparam int Z_W       = 18;
  localparam int SPD_W     = 20;
  localparam int STEP_W    = 18;
  localparam int SPEED_W   = 21;
  localparam int LEN_W     = 18;
  localparam int SPR_W     = 16;
  localparam int MPR_W     = 18;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;

  // Internal widths
  localparam int ZP_W    = 23;              // goal z minus pin offset, signed
  localparam int ZSQ_W   = 2 * ZP_W;        // square of ZP
  localparam int LSQ_W   = 2 * LEN_W;       // square of link length
  localparam int ROOT_W  = LEN_W;           // square root result
  localparam int RAD_W   = 2 * ROOT_W;      // radicand fed to the root unit
  localparam int G2_W    = 23;              // goal position, half-step Q, signed
  localparam int GM_W    = G2_W + SPR_W;    // |goal| * steps_per_rev
  localparam int CM_W    = STEP_W + MPR_W;  // |steps| * mm_per_rev
  localparam int QDIV_W  = 40;              // quotient width of the step dividers
  localparam int CUR_W   = 39;              // current position, signed
  localparam int DEL_W   = 40;              // signed travel
  localparam int ABS_W   = 38;              // travel magnitude
  localparam int SPLIT   = ABS_W / 2;       // partial product split point
  localparam int PLO_W   = SPLIT + SPD_W;
  localparam int PHI_W   = (ABS_W - SPLIT) + SPD_W;
  localparam int PROD_W  = ABS_W + SPD_W;   // travel * speed
  localparam int SN_W    = PROD_W + 1;      // rounded numerator

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_LENGTH     = 3'd0,
    CFG_CARRIAGE_OFFSET = 3'd1,
    CFG_END_OFFSET      = 3'd2,
    CFG_STEPS_PER_REV   = 3'd3,
    CFG_MM_PER_REV      = 3'd4
  } cfg_idx_t;

  // Sideband through the square root unit
  typedef struct packed {
    logic                     oob;
    logic signed [X_W-1:0]    x;
    logic [SPD_W-1:0]         spd;
    logic signed [STEP_W-1:0] ls;
    logic signed [STEP_W-1:0] rs;
  } sq_sb_t;

  // Sideband through the step dividers
  typedef struct packed {
    logic                   oob;
    logic [SPD_W-1:0]       spd;
    logic signed [G2_W-1:0] lg2;
    logic signed [G2_W-1:0] rg2;
    logic                   lc_neg;
    logic                   rc_neg;
    logic                   lg_neg;
    logic                   rg_neg;
  } dv_sb_t;

  // Sideband through the speed divider
  typedef struct packed {
    logic                      oob;
    logic signed [STEP_W-1:0]  lgs;
    logic signed [STEP_W-1:0]  rgs;
    logic signed [SPEED_W-1:0] lsp;
    logic signed [SPEED_W-1:0] rsp;
    logic                      scale;
    logic                      scale_l;
    logic                      sh_neg;
  } sp_sb_t;

  // Apply sign to an unsigned quotient and clamp to the step range
  function automatic logic signed [STEP_W-1:0] sat_steps(input logic neg,
                                                         input logic [QDIV_W-1:0] q);
    logic signed [STEP_W-1:0] res;
    if (neg) begin
      if (q > QDIV_W'(2 ** (STEP_W - 1))) begin
        res = $signed({1'b1, {(STEP_W-1){1'b0}}});
      end else begin
        res = $signed(-q[STEP_W-1:0]);
      end
    end else begin
      if (q > QDIV_W'(2 ** (STEP_W - 1) - 1)) begin
        res = $signed({1'b0, {(STEP_W-1){1'b1}}});
      end else begin
        res = $signed(q[STEP_W-1:0]);
      end
    end
    return res;
  endfunction

endpackage

@@ src/linear_delta_move_planner.sv @@
// ----------------------------------------------------------------------------
// linear_delta_move_planner: two-carriage linear delta inverse kinematics
// Turns a goal x,z and the carriages' step counts into goal steps and
// signed, arrival-matched motor speeds.
// ----------------------------------------------------------------------------
// Pipeline: 3 front stages, 18 root stages, 3 goal stages, 40 step-divider
//   stages, 6 travel stages, 20 speed-divider stages and the output register.
//   The bit-per-stage root and dividers make up most of those stages.
// Throughput: one beat per cycle; a stalled output freezes the whole pipe.
// Reset: clears all valid bits and loads the register defaults; no sweep.
module linear_delta_move_planner #(
  parameter int FRAC_BITS = ldm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ldm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ldm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ldm_pkg::X_W-1:0]    in_goal_x,
  input  logic [ldm_pkg::Z_W-1:0]           in_goal_z,
  input  logic [ldm_pkg::SPD_W-1:0]         in_move_speed,
  input  logic signed [ldm_pkg::STEP_W-1:0] in_left_steps,
  input  logic signed [ldm_pkg::STEP_W-1:0] in_right_steps,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_out_of_bounds,
  output logic signed [ldm_pkg::STEP_W-1:0] out_left_goal_steps,
  output logic signed [ldm_pkg::STEP_W-1:0] out_right_goal_steps,
  output logic signed [ldm_pkg::SPEED_W-1:0] out_left_speed,
  output logic signed [ldm_pkg::SPEED_W-1:0] out_right_speed
);
  import ldm_pkg::*;

  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam int ZOFF  = 20 * ONE_Q;
  localparam int ZMIN  = 50 * ONE_Q;
  localparam int ZMAX  = (3306 * ONE_Q + 5) / 10;
  localparam int GMAX  = 500 * ONE_Q;

  // --------------------------------------------------------------------------
  // Configuration registers
  logic [LEN_W-1:0] link_len_r, car_off_r, end_off_r;
  logic [SPR_W-1:0] spr_r, spr_e;
  logic [MPR_W-1:0] mpr_r, mpr_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_len_r <= '0;
      car_off_r  <= '0;
      end_off_r  <= '0;
      spr_r      <= SPR_W'(1);
      mpr_r      <= MPR_W'(256);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LINK_LENGTH:     link_len_r <= cfg_data[LEN_W-1:0];
        CFG_CARRIAGE_OFFSET: car_off_r  <= cfg_data[LEN_W-1:0];
        CFG_END_OFFSET:      end_off_r  <= cfg_data[LEN_W-1:0];
        CFG_STEPS_PER_REV:   spr_r      <= cfg_data[SPR_W-1:0];
        CFG_MM_PER_REV:      mpr_r      <= cfg_data[MPR_W-1:0];
        default: ;
      endcase
    end
  end

  // zero divisors act as one
  assign spr_e = (spr_r == '0) ? SPR_W'(1) : spr_r;
  assign mpr_e = (mpr_r == '0) ? MPR_W'(1) : mpr_r;

  // --------------------------------------------------------------------------
  // Global advance: the pipe moves unless the output beat is held
  logic out_valid_r, en;
  assign en       = ~(out_valid_r & ~out_ready);
  assign in_ready = en;

  // --------------------------------------------------------------------------
  // s1: capture, remove the z pin offset
  logic                     s1_v_r;
  logic signed [X_W-1:0]    s1_x_r;
  logic signed [ZP_W-1:0]   s1_zp_r, s1_zp_nxt;
  logic [SPD_W-1:0]         s1_spd_r;
  logic signed [STEP_W-1:0] s1_ls_r, s1_rs_r;

  assign s1_zp_nxt = ZP_W'($signed({1'b0, in_goal_z}) - ZOFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r   <= in_goal_x;
      s1_zp_r  <= s1_zp_nxt;
      s1_spd_r <= in_move_speed;
      s1_ls_r  <= in_left_steps;
      s1_rs_r  <= in_right_steps;
    end
  end

  // --------------------------------------------------------------------------
  // s2: squares and z bounds
  logic                     s2_v_r;
  logic signed [ZSQ_W-1:0]  s2_zsq_nxt;
  logic [ZSQ_W-1:0]         s2_zsq_r;
  logic [LSQ_W-1:0]         s2_lsq_r, s2_lsq_nxt;
  logic                     s2_zlo_r, s2_zhi_r;
  logic signed [X_W-1:0]    s2_x_r;
  logic [SPD_W-1:0]         s2_spd_r;
  logic signed [STEP_W-1:0] s2_ls_r, s2_rs_r;

  assign s2_zsq_nxt = s1_zp_r * s1_zp_r;
  assign s2_lsq_nxt = link_len_r * link_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_zsq_r <= s2_zsq_nxt;
      s2_lsq_r <= s2_lsq_nxt;
      s2_zlo_r <= (s1_zp_r < ZMIN);
      s2_zhi_r <= (s1_zp_r > ZMAX);
      s2_x_r   <= s1_x_r;
      s2_spd_r <= s1_spd_r;
      s2_ls_r  <= s1_ls_r;
      s2_rs_r  <= s1_rs_r;
    end
  end

  // --------------------------------------------------------------------------
  // s3: radicand and first bounds flag
  logic                   s3_v_r;
  logic signed [ZSQ_W:0]  s3_rad_s;
  logic                   s3_oob;
  logic [RAD_W-1:0]       s3_rad_r;
  sq_sb_t                 s3_sb_r;

  assign s3_rad_s = $signed({1'b0, ZSQ_W'(s2_lsq_r)}) - $signed({1'b0, s2_zsq_r});
  assign s3_oob   = s2_zlo_r | s2_zhi_r | (s3_rad_s < 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rad_r    <= s3_oob ? '0 : s3_rad_s[RAD_W-1:0];
      s3_sb_r.oob <= s3_oob;
      s3_sb_r.x   <= s2_x_r;
      s3_sb_r.spd <= s2_spd_r;
      s3_sb_r.ls  <= s2_ls_r;
      s3_sb_r.rs  <= s2_rs_r;
    end
  end

  // --------------------------------------------------------------------------
  // Square root of the radicand
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  sq_sb_t            sq_sb;

  ldm_sqrt #(
    .RW (ROOT_W),
    .SW ($bits(sq_sb_t))
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (s3_v_r),
    .rad_i  (s3_rad_r),
    .sb_i   (s3_sb_r),
    .v_o    (sq_v),
    .root_o (sq_root),
    .sb_o   (sq_sb)
  );

  // --------------------------------------------------------------------------
  // g1: goal carriage positions and the goal bound
  logic                     g1_v_r;
  logic signed [G2_W-1:0]   g1_h2, g1_x2, g1_rg2_nxt, g1_lg2_nxt;
  logic signed [G2_W-1:0]   g1_lg2_r, g1_rg2_r;
  logic                     g1_oob_r;
  logic [SPD_W-1:0]         g1_spd_r;
  logic signed [STEP_W-1:0] g1_ls_r, g1_rs_r;

  assign g1_h2      = G2_W'({sq_root, 1'b0}) + G2_W'(end_off_r) - G2_W'({car_off_r, 1'b0});
  assign g1_x2      = G2_W'($signed({sq_sb.x, 1'b0}));
  assign g1_rg2_nxt = g1_h2 + g1_x2;
  assign g1_lg2_nxt = g1_h2 - g1_x2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_v_r <= 1'b0;
    end else if (en) begin
      g1_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_lg2_r <= g1_lg2_nxt;
      g1_rg2_r <= g1_rg2_nxt;
      g1_oob_r <= sq_sb.oob | (g1_rg2_nxt > GMAX) | (g1_lg2_nxt > GMAX);
      g1_spd_r <= sq_sb.spd;
      g1_ls_r  <= sq_sb.ls;
      g1_rs_r  <= sq_sb.rs;
    end
  end

  // --------------------------------------------------------------------------
  // g2: magnitudes times the unit ratios
  logic              g2_v_r;
  logic [G2_W-1:0]   g2_lg_abs, g2_rg_abs;
  logic [STEP_W-1:0] g2_lc_abs, g2_rc_abs;
  logic [GM_W-1:0]   g2_lgm_nxt, g2_rgm_nxt, g2_lgm_r, g2_rgm_r;
  logic [CM_W-1:0]   g2_lcm_nxt, g2_rcm_nxt, g2_lcm_r, g2_rcm_r;
  dv_sb_t            g2_sb_r;

  assign g2_lg_abs  = G2_W'(g1_lg2_r < 0 ? -g1_lg2_r : g1_lg2_r);
  assign g2_rg_abs  = G2_W'(g1_rg2_r < 0 ? -g1_rg2_r : g1_rg2_r);
  assign g2_lc_abs  = STEP_W'(g1_ls_r < 0 ? -g1_ls_r : g1_ls_r);
  assign g2_rc_abs  = STEP_W'(g1_rs_r < 0 ? -g1_rs_r : g1_rs_r);
  assign g2_lgm_nxt = g2_lg_abs * spr_e;
  assign g2_rgm_nxt = g2_rg_abs * spr_e;
  assign g2_lcm_nxt = g2_lc_abs * mpr_e;
  assign g2_rcm_nxt = g2_rc_abs * mpr_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2_v_r <= 1'b0;
    end else if (en) begin
      g2_v_r <= g1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g2_lgm_r       <= g2_lgm_nxt;
      g2_rgm_r       <= g2_rgm_nxt;
      g2_lcm_r       <= g2_lcm_nxt;
      g2_rcm_r       <= g2_rcm_nxt;
      g2_sb_r.oob    <= g1_oob_r;
      g2_sb_r.spd    <= g1_spd_r;
      g2_sb_r.lg2    <= g1_lg2_r;
      g2_sb_r.rg2    <= g1_rg2_r;
      g2_sb_r.lc_neg <= (g1_ls_r < 0);
      g2_sb_r.rc_neg <= (g1_rs_r < 0);
      g2_sb_r.lg_neg <= (g1_lg2_r < 0);
      g2_sb_r.rg_neg <= (g1_rg2_r < 0);
    end
  end

  // --------------------------------------------------------------------------
  // g3: add half the divisor for round-to-nearest
  logic              g3_v_r;
  logic [QDIV_W-1:0] g3_lgn_r, g3_rgn_r, g3_lcn_r, g3_rcn_r;
  dv_sb_t            g3_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g3_v_r <= 1'b0;
    end else if (en) begin
      g3_v_r <= g2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g3_lgn_r <= QDIV_W'(g2_lgm_r) + QDIV_W'(mpr_e);
      g3_rgn_r <= QDIV_W'(g2_rgm_r) + QDIV_W'(mpr_e);
      g3_lcn_r <= QDIV_W'({g2_lcm_r, 1'b0}) + QDIV_W'(spr_e >> 1);
      g3_rcn_r <= QDIV_W'({g2_rcm_r, 1'b0}) + QDIV_W'(spr_e >> 1);
      g3_sb_r  <= g2_sb_r;
    end
  end

  // --------------------------------------------------------------------------
  // Step dividers: current position in half-step Q, goal in steps
  logic              dv_v;
  logic [QDIV_W-1:0] dv_lcq, dv_rcq, dv_lgq, dv_rgq;
  dv_sb_t            dv_sb;

  ldm_div #(
    .NW (QDIV_W), .DW (SPR_W), .QW (QDIV_W), .SW ($bits(dv_sb_t))
  ) u_div_lc (
    .clk (clk), .rst_n (rst_n), .en (en), .v_i (g3_v_r),
    .n_i (g3_lcn_r), .d_i (spr_e), .sb_i (g3_sb_r),
    .v_o (dv_v), .q_o (dv_lcq), .sb_o (dv_sb)
  );

  ldm_div #(
    .NW (QDIV_W), .DW (SPR_W), .QW (QDIV_W), .SW (1)
  ) u_div_rc (
    .clk (clk), .rst_n (rst_n), .en (en), .v_i (g3_v_r),
    .n_i (g3_rcn_r), .d_i (spr_e), .sb_i (1'b0),
    .v_o (), .q_o (dv_rcq), .sb_o ()
  );

  ldm_div #(
    .NW (QDIV_W), .DW (MPR_W + 1), .QW (QDIV_W), .SW (1)
  ) u_div_lg (
    .clk (clk), .rst_n (rst_n), .en (en), .v_i (g3_v_r),
    .n_i (g3_lgn_r), .d_i ({mpr_e, 1'b0}), .sb_i (1'b0),
    .v_o (), .q_o (dv_lgq), .sb_o ()
  );

  ldm_div #(
    .NW (QDIV_W), .DW (MPR_W + 1), .QW (QDIV_W), .SW (1)
  ) u_div_rg (
    .clk (clk), .rst_n (rst_n), .en (en), .v_i (g3_v_r),
    .n_i (g3_rgn_r), .d_i ({mpr_e, 1'b0}), .sb_i (1'b0),
    .v_o (), .q_o (dv_rgq), .sb_o ()
  );

  // --------------------------------------------------------------------------
  // d1: restore signs, saturate goal steps
  logic                     d1_v_r;
  logic signed [CUR_W-1:0]  d1_lcm, d1_rcm, d1_lcur_r, d1_rcur_r;
  logic signed [STEP_W-1:0] d1_lgs_r, d1_rgs_r;
  logic signed [G2_W-1:0]   d1_lg2_r, d1_rg2_r;
  logic [SPD_W-1:0]         d1_spd_r;
  logic                     d1_oob_r;

  assign d1_lcm = $signed({1'b0, dv_lcq[CUR_W-2:0]});
  assign d1_rcm = $signed({1'b0, dv_rcq[CUR_W-2:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_lcur_r <= dv_sb.lc_neg ? -d1_lcm : d1_lcm;
      d1_rcur_r <= dv_sb.rc_neg ? -d1_rcm : d1_rcm;
      d1_lgs_r  <= sat_steps(dv_sb.lg_neg, dv_lgq);
      d1_rgs_r  <= sat_steps(dv_sb.rg_neg, dv_rgq);
      d1_lg2_r  <= dv_sb.lg2;
      d1_rg2_r  <= dv_sb.rg2;
      d1_spd_r  <= dv_sb.spd;
      d1_oob_r  <= dv_sb.oob;
    end
  end

  // --------------------------------------------------------------------------
  // d2: signed travel of each carriage
  logic                     d2_v_r;
  logic signed [DEL_W-1:0]  d2_ldel_r, d2_rdel_r;
  logic signed [STEP_W-1:0] d2_lgs_r, d2_rgs_r;
  logic [SPD_W-1:0]         d2_spd_r;
  logic                     d2_oob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r <= 1'b0;
    end else if (en) begin
      d2_v_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_ldel_r <= DEL_W'(d1_lcur_r) - DEL_W'(d1_lg2_r);
      d2_rdel_r <= DEL_W'(d1_rcur_r) - DEL_W'(d1_rg2_r);
      d2_lgs_r  <= d1_lgs_r;
      d2_rgs_r  <= d1_rgs_r;
      d2_spd_r  <= d1_spd_r;
      d2_oob_r  <= d1_oob_r;
    end
  end

  // --------------------------------------------------------------------------
  // d3: directions, magnitudes, pick the shorter travel
  logic                      d3_v_r;
  logic [ABS_W-1:0]          d3_labs, d3_rabs, d3_short_r, d3_long_r;
  logic signed [SPEED_W-1:0] d3_sp, d3_lsp_nxt, d3_rsp_nxt, d3_lsp_r, d3_rsp_r;
  logic                      d3_lgt, d3_rgt;
  logic                      d3_shneg_r, d3_scale_l_r, d3_uneq_r;
  logic signed [STEP_W-1:0]  d3_lgs_r, d3_rgs_r;
  logic [SPD_W-1:0]          d3_spd_r;
  logic                      d3_oob_r;

  assign d3_labs = ABS_W'(d2_ldel_r < 0 ? -d2_ldel_r : d2_ldel_r);
  assign d3_rabs = ABS_W'(d2_rdel_r < 0 ? -d2_rdel_r : d2_rdel_r);
  assign d3_lgt  = (d3_labs > d3_rabs);
  assign d3_rgt  = (d3_labs < d3_rabs);
  assign d3_sp   = $signed({1'b0, d2_spd_r});

  // carriage above its goal moves with positive speed
  assign d3_lsp_nxt = (d2_ldel_r > 0) ? d3_sp : ((d2_ldel_r < 0) ? -d3_sp : '0);
  assign d3_rsp_nxt = (d2_rdel_r > 0) ? d3_sp : ((d2_rdel_r < 0) ? -d3_sp : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d3_v_r <= 1'b0;
    end else if (en) begin
      d3_v_r <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_short_r   <= d3_lgt ? d3_rabs : d3_labs;
      d3_long_r    <= d3_lgt ? d3_labs : d3_rabs;
      d3_shneg_r   <= d3_lgt ? (d2_rdel_r < 0) : (d2_ldel_r < 0);
      d3_scale_l_r <= d3_rgt;
      d3_uneq_r    <= d3_lgt | d3_rgt;
      d3_lsp_r     <= d3_lsp_nxt;
      d3_rsp_r     <= d3_rsp_nxt;
      d3_lgs_r     <= d2_lgs_r;
      d3_rgs_r     <= d2_rgs_r;
      d3_spd_r     <= d2_spd_r;
      d3_oob_r     <= d2_oob_r;
    end
  end

  // --------------------------------------------------------------------------
  // d4: low partial product of short travel times speed
  logic                    d4_v_r;
  logic [PLO_W-1:0]        d4_plo_nxt, d4_plo_r;
  logic [ABS_W-SPLIT-1:0]  d4_shi_r;
  logic [ABS_W-1:0]        d4_long_r;
  logic [SPD_W-1:0]        d4_spd_r;
  sp_sb_t                  d4_sb_r;

  assign d4_plo_nxt = d3_short_r[SPLIT-1:0] * d3_spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d4_v_r <= 1'b0;
    end else if (en) begin
      d4_v_r <= d3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4_plo_r        <= d4_plo_nxt;
      d4_shi_r        <= d3_short_r[ABS_W-1:SPLIT];
      d4_long_r       <= d3_long_r;
      d4_spd_r        <= d3_spd_r;
      d4_sb_r.oob     <= d3_oob_r;
      d4_sb_r.lgs     <= d3_lgs_r;
      d4_sb_r.rgs     <= d3_rgs_r;
      d4_sb_r.lsp     <= d3_lsp_r;
      d4_sb_r.rsp     <= d3_rsp_r;
      d4_sb_r.scale   <= d3_uneq_r;
      d4_sb_r.scale_l <= d3_scale_l_r;
      d4_sb_r.sh_neg  <= d3_shneg_r;
    end
  end

  // --------------------------------------------------------------------------
  // d5: high partial product and full product
  logic             d5_v_r;
  logic [PHI_W-1:0] d5_phi;
  logic [PROD_W-1:0] d5_prod_r;
  logic [ABS_W-1:0] d5_long_r;
  sp_sb_t           d5_sb_r;

  assign d5_phi = d4_shi_r * d4_spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d5_v_r <= 1'b0;
    end else if (en) begin
      d5_v_r <= d4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d5_prod_r <= PROD_W'(d4_plo_r) + (PROD_W'(d5_phi) << SPLIT);
      d5_long_r <= d4_long_r;
      d5_sb_r   <= d4_sb_r;
    end
  end

  // --------------------------------------------------------------------------
  // d6: deadband test and rounded numerator
  logic             d6_v_r;
  logic [SN_W-1:0]  d6_num_r;
  logic [ABS_W-1:0] d6_long_r;
  logic             d6_cond;
  sp_sb_t           d6_sb_r, d6_sb_nxt;

  // scaled speed of at least one unit
  assign d6_cond = (d5_prod_r >= (PROD_W'(d5_long_r) << FRAC_BITS));

  // keep scaling only above the deadband
  always_comb begin
    d6_sb_nxt       = d5_sb_r;
    d6_sb_nxt.scale = d5_sb_r.scale & d6_cond;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d6_v_r <= 1'b0;
    end else if (en) begin
      d6_v_r <= d5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d6_num_r  <= SN_W'(d5_prod_r) + SN_W'(d5_long_r >> 1);
      d6_long_r <= d5_long_r;
      d6_sb_r   <= d6_sb_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Speed divider: short * speed / long
  logic             sp_v;
  logic [SPD_W-1:0] sp_q;
  sp_sb_t           sp_sb;

  ldm_div #(
    .NW (SN_W), .DW (ABS_W), .QW (SPD_W), .SW ($bits(sp_sb_t))
  ) u_div_sp (
    .clk (clk), .rst_n (rst_n), .en (en), .v_i (d6_v_r),
    .n_i (d6_num_r), .d_i (d6_long_r), .sb_i (d6_sb_r),
    .v_o (sp_v), .q_o (sp_q), .sb_o (sp_sb)
  );

  // --------------------------------------------------------------------------
  // Output register: select scaled speed, zero steps and speeds when out of bounds
  logic signed [SPEED_W-1:0] o_m, o_ms, o_lsp, o_rsp;
  logic                      out_oob_r;
  logic signed [STEP_W-1:0]  out_lgs_r, out_rgs_r;
  logic signed [SPEED_W-1:0] out_lsp_r, out_rsp_r;

  assign o_m   = $signed({1'b0, sp_q});
  assign o_ms  = sp_sb.sh_neg ? -o_m : o_m;
  assign o_lsp = (sp_sb.scale & sp_sb.scale_l) ? o_ms : sp_sb.lsp;
  assign o_rsp = (sp_sb.scale & ~sp_sb.scale_l) ? o_ms : sp_sb.rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_oob_r <= sp_sb.oob;
      out_lgs_r <= sp_sb.oob ? '0 : sp_sb.lgs;
      out_rgs_r <= sp_sb.oob ? '0 : sp_sb.rgs;
      out_lsp_r <= sp_sb.oob ? '0 : o_lsp;
      out_rsp_r <= sp_sb.oob ? '0 : o_rsp;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_out_of_bounds    = out_oob_r;
  assign out_left_goal_steps  = out_lgs_r;
  assign out_right_goal_steps = out_rgs_r;
  assign out_left_speed       = out_lsp_r;
  assign out_right_speed      = out_rsp_r;

endmodule

@@ src/ldm_sqrt.sv @@
// ----------------------------------------------------------------------------
// ldm_sqrt: pipelined integer square root
// One result bit per stage, floor of the root, with a sideband word that
// travels alongside. All stages advance together on en.
// ----------------------------------------------------------------------------
module ldm_sqrt #(
  parameter int RW = 18,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SW-1:0]   sb_i,
  output logic            v_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   sb_o
);

  logic            vld_r  [RW];
  logic [RW:0]     rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rest_r [RW];
  logic [SW-1:0]   sb_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            prv_v;
    logic [RW:0]     prv_rem;
    logic [RW-1:0]   prv_root;
    logic [2*RW-1:0] prv_rest;
    logic [SW-1:0]   prv_sb;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign prv_v    = v_i;
      assign prv_rem  = '0;
      assign prv_root = '0;
      assign prv_rest = rad_i;
      assign prv_sb   = sb_i;
    end else begin : g_next
      assign prv_v    = vld_r[k-1];
      assign prv_rem  = rem_r[k-1];
      assign prv_root = root_r[k-1];
      assign prv_rest = rest_r[k-1];
      assign prv_sb   = sb_r[k-1];
    end

    // bring down the next bit pair and try root*4+1
    assign rem_sh = {prv_rem, prv_rest[2*RW-1 -: 2]};
    assign trial  = (RW+3)'({prv_root, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= prv_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
        root_r[k] <= {prv_root[RW-2:0], ge};
        rest_r[k] <= prv_rest << 2;
        sb_r[k]   <= prv_sb;
      end
    end
  end

  assign v_o    = vld_r[RW-1];
  assign root_o = root_r[RW-1];
  assign sb_o   = sb_r[RW-1];

endmodule

@@ src/ldm_div.sv @@
// ----------------------------------------------------------------------------
// ldm_div: pipelined unsigned restoring divider
// One quotient bit per stage. The numerator must be below d << QW. The
// divisor travels with its item, so it may change every beat.
// ----------------------------------------------------------------------------
module ldm_div #(
  parameter int NW = 40,
  parameter int DW = 16,
  parameter int QW = 40,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  logic [SW-1:0] sb_i,
  output logic          v_o,
  output logic [QW-1:0] q_o,
  output logic [SW-1:0] sb_o
);

  logic [NW+DW:0] ext;
  logic           vld_r [QW];
  logic [DW-1:0]  rem_r [QW];
  logic [QW-1:0]  sh_r  [QW];
  logic [DW-1:0]  d_r   [QW];
  logic [SW-1:0]  sb_r  [QW];

  assign ext = (NW+DW+1)'(n_i);

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          prv_v;
    logic [DW-1:0] prv_rem;
    logic [QW-1:0] prv_sh;
    logic [DW-1:0] prv_d;
    logic [SW-1:0] prv_sb;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign prv_v   = v_i;
      assign prv_rem = ext[QW +: DW];
      assign prv_sh  = n_i[QW-1:0];
      assign prv_d   = d_i;
      assign prv_sb  = sb_i;
    end else begin : g_next
      assign prv_v   = vld_r[k-1];
      assign prv_rem = rem_r[k-1];
      assign prv_sh  = sh_r[k-1];
      assign prv_d   = d_r[k-1];
      assign prv_sb  = sb_r[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign rem_sh = {prv_rem, prv_sh[QW-1]};
    assign ge     = (rem_sh >= {1'b0, prv_d});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= prv_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(rem_sh - {1'b0, prv_d}) : DW'(rem_sh);
        sh_r[k]  <= {prv_sh[QW-2:0], ge};
        d_r[k]   <= prv_d;
        sb_r[k]  <= prv_sb;
      end
    end
  end

  assign v_o  = vld_r[QW-1];
  assign q_o  = sh_r[QW-1];
  assign sb_o = sb_r[QW-1];

endmodule

@@ src/ldm_checker.sv @@
// ----------------------------------------------------------------------------
// ldm_checker: port-level assertions for the move planner
// Watches the result channel and the stall coupling of the two channels.
// ----------------------------------------------------------------------------
module ldm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_we,
  input logic [ldm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [ldm_pkg::CFG_W-1:0]         cfg_data,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic signed [ldm_pkg::X_W-1:0]    in_goal_x,
  input logic [ldm_pkg::Z_W-1:0]           in_goal_z,
  input logic [ldm_pkg::SPD_W-1:0]         in_move_speed,
  input logic signed [ldm_pkg::STEP_W-1:0] in_left_steps,
  input logic signed [ldm_pkg::STEP_W-1:0] in_right_steps,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_out_of_bounds,
  input logic signed [ldm_pkg::STEP_W-1:0] out_left_goal_steps,
  input logic signed [ldm_pkg::STEP_W-1:0] out_right_goal_steps,
  input logic signed [ldm_pkg::SPEED_W-1:0] out_left_speed,
  input logic signed [ldm_pkg::SPEED_W-1:0] out_right_speed
);
  import ldm_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_of_bounds) &&
      $stable(out_left_speed) && $stable(out_right_speed) &&
      $stable(out_left_goal_steps) && $stable(out_right_goal_steps))
    else $error("stalled result beat changed");

  // out of bounds results carry zero fields
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_bounds |-> out_left_goal_steps == 0 &&
      out_right_goal_steps == 0 && out_left_speed == 0 && out_right_speed == 0)
    else $error("out of bounds result with nonzero fields");

  // input stalls exactly when the output beat is held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !(out_valid && !out_ready))
    else $error("input ready does not follow output stall");

  // reset drops the result channel
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind linear_delta_move_planner ldm_checker u_ldm_checker (.*);

@@ sim/linear_delta_move_planner_test.sv @@
// ----------------------------------------------------------------------------
// linear_delta_move_planner_test: self-checking bench for the move planner
// Drives move commands over valid/ready and predicts every plan in the
// bench. Each output beat is checked field by field against the oldest
// prediction. Directed edge cases come first, then random phases under
// several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module linear_delta_move_planner_test;
  import ldm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC   = 8;
  localparam longint QONE = longint'(1) << FRAC;
  localparam longint MM  = QONE;

  typedef struct {
    logic signed [X_W-1:0]    goal_x;
    logic [Z_W-1:0]           goal_z;
    logic [SPD_W-1:0]         speed;
    logic signed [STEP_W-1:0] lsteps;
    logic signed [STEP_W-1:0] rsteps;
  } move_cmd_t;

  typedef struct {
    logic                      oob;
    logic signed [STEP_W-1:0]  lgoal;
    logic signed [STEP_W-1:0]  rgoal;
    logic signed [SPEED_W-1:0] lspeed;
    logic signed [SPEED_W-1:0] rspeed;
  } move_plan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [X_W-1:0] in_goal_x = '0;
  logic [Z_W-1:0] in_goal_z = '0;
  logic [SPD_W-1:0] in_move_speed = '0;
  logic signed [STEP_W-1:0] in_left_steps = '0;
  logic signed [STEP_W-1:0] in_right_steps = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_out_of_bounds;
  logic signed [STEP_W-1:0] out_left_goal_steps;
  logic signed [STEP_W-1:0] out_right_goal_steps;
  logic signed [SPEED_W-1:0] out_left_speed;
  logic signed [SPEED_W-1:0] out_right_speed;

  // bench copy of the registers
  longint link_len = 0;
  longint carr_ofs = 0;
  longint end_ofs = 0;
  longint steps_rev = 1;
  longint mm_rev = 256;

  move_plan_t expected_plans[$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  linear_delta_move_planner u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round to nearest, ties away from zero
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp_steps(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // inverse kinematics and arrival-matched speeds for one command
  function automatic move_plan_t plan_move(move_cmd_t c);
    move_plan_t p;
    longint x, z, spd, ls, rs, spr, mpr, zmax, rad, h2, lg2, rg2;
    longint lcur, rcur, ldel, rdel, lsp, rsp, m;
    bit oob;
    x = c.goal_x;
    z = c.goal_z;
    spd = c.speed;
    ls = c.lsteps;
    rs = c.rsteps;
    spr = steps_rev != 0 ? steps_rev : 1;
    mpr = mm_rev != 0 ? mm_rev : 1;
    zmax = (3306 * QONE + 5) / 10;
    p = '{default: '0};
    z -= 20 * MM;
    rad = link_len * link_len - z * z;
    oob = (z < 50 * MM) || (z > zmax) || (rad < 0);
    h2 = oob ? 0 : 2 * int_sqrt(longint'(rad)) + end_ofs - 2 * carr_ofs;
    rg2 = 2 * x + h2;
    lg2 = h2 - 2 * x;
    if (rg2 > 500 * MM || lg2 > 500 * MM) oob = 1;
    if (oob) begin
      p.oob = 1'b1;
      return p;
    end
    lcur = round_div(ls * mpr * 2, spr);
    rcur = round_div(rs * mpr * 2, spr);
    ldel = lcur - lg2;
    rdel = rcur - rg2;
    lsp = ldel > 0 ? spd : (ldel < 0 ? -spd : 0);
    rsp = rdel > 0 ? spd : (rdel < 0 ? -spd : 0);
    if (ldel < 0) ldel = -ldel;
    if (rdel < 0) rdel = -rdel;
    // slow the shorter travel unless it drops under the deadband
    if (ldel > rdel) begin
      if (rdel * spd >= ldel * QONE) begin
        m = (rdel * spd + ldel / 2) / ldel;
        rsp = rsp < 0 ? -m : m;
      end
    end else if (ldel < rdel) begin
      if (ldel * spd >= rdel * QONE) begin
        m = (ldel * spd + rdel / 2) / rdel;
        lsp = lsp < 0 ? -m : m;
      end
    end
    p.lgoal = STEP_W'(clamp_steps(round_div(lg2 * spr, 2 * mpr)));
    p.rgoal = STEP_W'(clamp_steps(round_div(rg2 * spr, 2 * mpr)));
    p.lspeed = SPEED_W'(lsp);
    p.rspeed = SPEED_W'(rsp);
    return p;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // check each output beat against the oldest prediction
  always @(posedge clk) begin
    move_plan_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_plans.size() == 0) begin
        $display("%0t: unexpected beat oob=%0d", $time, out_out_of_bounds);
        err_count++;
      end else begin
        e = expected_plans.pop_front();
        if (out_out_of_bounds !== e.oob) begin
          $display("%0t: out_of_bounds exp %0d got %0d", $time, e.oob, out_out_of_bounds);
          err_count++;
        end
        if (out_left_goal_steps !== e.lgoal) begin
          $display("%0t: left_goal_steps exp %0d got %0d", $time, e.lgoal,
                   out_left_goal_steps);
          err_count++;
        end
        if (out_right_goal_steps !== e.rgoal) begin
          $display("%0t: right_goal_steps exp %0d got %0d", $time, e.rgoal,
                   out_right_goal_steps);
          err_count++;
        end
        if (out_left_speed !== e.lspeed) begin
          $display("%0t: left_speed exp %0d got %0d", $time, e.lspeed, out_left_speed);
          err_count++;
        end
        if (out_right_speed !== e.rspeed) begin
          $display("%0t: right_speed exp %0d got %0d", $time, e.rspeed, out_right_speed);
          err_count++;
        end
      end
    end
  end

  // send one command beat and record its plan on acceptance
  task automatic send_move(move_cmd_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_goal_x <= c.goal_x;
    in_goal_z <= c.goal_z;
    in_move_speed <= c.speed;
    in_left_steps <= c.lsteps;
    in_right_steps <= c.rsteps;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_plans.push_back(plan_move(c));
  endtask

  // hold the sender until every plan has come back, then let the pipe settle
  task automatic drain_plans();
    in_valid <= 1'b0;
    while (expected_plans.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_regs(longint l, longint c, longint e, longint s, longint m);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LINK_LENGTH;
    cfg_data <= CFG_W'(l);
    @(posedge clk);
    cfg_index <= CFG_CARRIAGE_OFFSET;
    cfg_data <= CFG_W'(c);
    @(posedge clk);
    cfg_index <= CFG_END_OFFSET;
    cfg_data <= CFG_W'(e);
    @(posedge clk);
    cfg_index <= CFG_STEPS_PER_REV;
    cfg_data <= CFG_W'(s);
    @(posedge clk);
    cfg_index <= CFG_MM_PER_REV;
    cfg_data <= CFG_W'(m);
    @(posedge clk);
    cfg_we <= 1'b0;
    link_len = l & 'h3FFFF;
    carr_ofs = c & 'h3FFFF;
    end_ofs = e & 'h3FFFF;
    steps_rev = s & 'hFFFF;
    mm_rev = m & 'h3FFFF;
  endtask

  function automatic move_cmd_t make_cmd(longint x, longint z, longint s,
                                         longint l, longint r);
    move_cmd_t c;
    c.goal_x = X_W'(x);
    c.goal_z = Z_W'(z);
    c.speed = SPD_W'(s);
    c.lsteps = STEP_W'(l);
    c.rsteps = STEP_W'(r);
    return c;
  endfunction

  // fully random fields, or a reachable goal with carriages near it
  function automatic move_cmd_t rand_cmd();
    move_cmd_t c;
    move_plan_t p;
    c = make_cmd($urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(99) < 20) return c;
    c.goal_z = Z_W'(70 * MM + $urandom_range(0, 290 * MM));
    c.goal_x = X_W'($signed($urandom_range(0, 240 * MM)) - 120 * MM);
    c.lsteps = '0;
    c.rsteps = '0;
    p = plan_move(c);
    c.lsteps = p.lgoal + STEP_W'($signed($urandom_range(0, 4000)) - 2000);
    c.rsteps = p.rgoal + STEP_W'($signed($urandom_range(0, 4000)) - 2000);
    if ($urandom_range(9) == 0) c.lsteps = p.lgoal;
    if ($urandom_range(9) == 0) c.speed = SPD_W'($urandom_range(0, 600));
    return c;
  endfunction

  // registers at reset: nothing is reachable
  task automatic test_reset_defaults();
    send_move(make_cmd(0, 120 * MM, 1000, 0, 0));
    send_move(make_cmd(-262144, 262143, 1048575, -131072, 131071));
    send_move(make_cmd(262143, 0, 0, 131071, -131072));
    drain_plans();
  endtask

  // bounds, zero and equal travel, deadband, scaling
  task automatic test_edge_cases();
    move_cmd_t c;
    move_plan_t p;
    longint zmax;
    zmax = (3306 * QONE + 5) / 10;
    set_regs(300 * MM, 80 * MM, 60 * MM, 1, 1);
    send_move(make_cmd(0, 70 * MM - 1, 500, 0, 0));
    send_move(make_cmd(0, 70 * MM, 500, 0, 0));
    send_move(make_cmd(0, 20 * MM + zmax, 500, 0, 0));
    send_move(make_cmd(0, 20 * MM + zmax + 1, 500, 0, 0));
    send_move(make_cmd(200 * MM, 150 * MM, 500, 0, 0));
    send_move(make_cmd(-200 * MM, 150 * MM, 500, 0, 0));
    c = make_cmd(0, 120 * MM, 1000, 0, 0);
    p = plan_move(c);
    c.lsteps = p.lgoal;
    c.rsteps = p.rgoal;
    send_move(c);
    c.lsteps = p.lgoal + 1;
    send_move(c);
    c.lsteps = p.lgoal + 3000;
    c.rsteps = p.rgoal - 3000;
    send_move(c);
    c.lsteps = p.lgoal + 100;
    c.rsteps = p.rgoal + 1;
    c.speed = 300;
    send_move(c);
    c.lsteps = p.lgoal - 50000;
    c.rsteps = p.rgoal + 17;
    c.speed = 1048575;
    send_move(c);
    c.lsteps = -131072;
    c.rsteps = 131071;
    c.speed = 0;
    send_move(c);
    c.speed = 1048575;
    send_move(c);
    drain_plans();
    // short link: z' beyond it, then just inside it
    set_regs(60 * MM, 0, 0, 65535, 262143);
    send_move(make_cmd(0, 200 * MM, 500, 0, 0));
    send_move(make_cmd(0, 75 * MM, 500, 131071, -131072));
    drain_plans();
  endtask

  task automatic run_random(int n, int idle, int stall, bit pause_mid);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain_plans();
      send_move(rand_cmd());
    end
    drain_plans();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_nominal_streaming();
    set_regs(300 * MM, 80 * MM, 60 * MM, 200, 8 * MM);
    run_random(440, 0, 0, 0);
  endtask

  task automatic test_register_maxima();
    set_regs(262143, 262143, 0, 65535, 262143);
    run_random(200, 68, 0, 1);
    set_regs(262143, 0, 262143, 65535, 1);
    run_random(200, 68, 0, 0);
  endtask

  task automatic test_zero_divisors();
    set_regs(300 * MM, 80 * MM, 60 * MM, 0, 0);
    run_random(440, 0, 68, 0);
  endtask

  task automatic test_mixed_backpressure();
    set_regs(250 * MM, 60 * MM, 30 * MM, 400, 2 * MM);
    run_random(440, 23, 23, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_edge_cases();
    test_nominal_streaming();
    test_register_maxima();
    test_zero_divisors();
    test_mixed_backpressure();
    if (expected_plans.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("linear_delta_move_planner_test: done, clean");
    end else begin
      $display("linear_delta_move_planner_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("linear_delta_move_planner_test: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
src/ldm_pkg.sv
src/ldm_sqrt.sv
src/ldm_div.sv
src/linear_delta_move_planner.sv
src/ldm_checker.sv
sim/linear_delta_move_planner_test.sv
